// ----- src/blmd_pkg.sv -----
// ----------------------------------------------------------------------------
// blmd_pkg: shared types and constants for the BLE-MIDI packet deframer
// Parser phase, parser state, result item and the MIDI status codes used by
// the decoder and the result queue.
// ----------------------------------------------------------------------------
package blmd_pkg;

  // Parser phase within a packet
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_STAMP  = 2'd2
  } phase_e;

  // MIDI status codes
  localparam logic [7:0] ST_NONE       = 8'h00;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END  = 8'hF7;
  localparam logic [7:0] ST_REALTIME   = 8'hF8;
  localparam logic [7:0] ST_SYSTEM_MIN = 8'hF0;

  // Upper nibbles of status bytes
  localparam logic [3:0] HI_PROGRAM  = 4'b1100;
  localparam logic [3:0] HI_PRESSURE = 4'b1101;
  localparam logic [3:0] HI_SYSTEM   = 4'b1111;

  // Lower nibbles of system common statuses
  localparam logic [3:0] LO_QFRAME  = 4'b0001;
  localparam logic [3:0] LO_SONGPOS = 4'b0010;
  localparam logic [3:0] LO_SONGSEL = 4'b0011;

  // Result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // Parser state
  typedef struct packed {
    phase_e     phase;
    logic [7:0] running_status;
    logic [1:0] data_needed;
    logic [1:0] data_seen;
    logic       in_sysex;
    logic       status_sent;
  } state_t;

  // One output item
  typedef struct packed {
    logic [7:0] midi_byte;
    logic       end_of_message;
    logic       last_for_input;
  } result_t;

  // Results caused by one input byte
  typedef struct packed {
    logic [1:0] count;
    result_t    res1;
    result_t    res0;
  } dec_out_t;

endpackage

// ----- src/ble_midi_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// ble_midi_packet_deframer: BLE-MIDI packet bytes in, plain MIDI bytes out
// Input stream: one packet byte per transaction, tdata = packet byte,
// tuser = first_of_packet (marks the header byte, which is dropped).
// Output stream: one MIDI byte per transaction, tlast = end of message,
// tuser = last result caused by the input byte.
// Each input byte yields zero, one or two MIDI bytes; running status is
// re-emitted in front of its data and sysex runs across packets until F7
// or another non-real-time status. Results pass through a queue register.
// Throughput: one input byte per cycle while output is drained; the output
// side delivers one byte per cycle, so bytes that give two results limit
// the input rate to the output rate. A four-entry result queue sets this.
// Input tready depends only on queue fill, never on m_axis_tready directly.
// Reset clears the parser (expect header, no running status, no sysex) and
// empties the queue. When the receiver stalls, results wait in the queue
// and the input is held off once fewer than two entries are free.
// ----------------------------------------------------------------------------
module ble_midi_packet_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] packet_byte
  input  logic       s_axis_tuser,   // [0] first_of_packet
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] midi_byte
  output logic       m_axis_tlast,   // end_of_message
  output logic       m_axis_tuser    // [0] last_for_input
);

  blmd_pkg::state_t   state_q, state_d, state_nx;
  blmd_pkg::dec_out_t dec, push;
  blmd_pkg::result_t  head;
  logic               accept;
  logic               space;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = space;

  // Per-byte parser logic
  blmd_decode u_decode (
    .state_i (state_q),
    .byte_i  (s_axis_tdata),
    .first_i (s_axis_tuser),
    .state_o (state_nx),
    .dec_o   (dec)
  );

  // Parser state register, updated on each transaction
  assign state_d = accept ? state_nx : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= blmd_pkg::PH_HEADER;
      state_q.running_status <= blmd_pkg::ST_NONE;
      state_q.data_needed    <= 2'd0;
      state_q.data_seen      <= 2'd0;
      state_q.in_sysex       <= 1'b0;
      state_q.status_sent    <= 1'b0;
    end else begin
      state_q <= state_d;
    end
  end

  // Results enter the queue only on a transaction
  always_comb begin
    push = dec;
    if (!accept) push.count = 2'd0;
  end

  blmd_res_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tvalid & m_axis_tready),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .head_o  (head)
  );

  assign m_axis_tdata = head.midi_byte;
  assign m_axis_tlast = head.end_of_message;
  assign m_axis_tuser = head.last_for_input;

endmodule

// ----- src/blmd_decode.sv -----
// ----------------------------------------------------------------------------
// blmd_decode: per-byte parser logic
// From the current parser state and one packet byte, works out the next
// state and the zero, one or two MIDI bytes that the byte produces.
// ----------------------------------------------------------------------------
module blmd_decode (
  input  blmd_pkg::state_t   state_i,
  input  logic [7:0]         byte_i,
  input  logic               first_i,
  output blmd_pkg::state_t   state_o,
  output blmd_pkg::dec_out_t dec_o
);

  blmd_pkg::state_t  st;
  blmd_pkg::result_t res [2];
  logic [1:0]        cnt;
  logic              do_data;
  logic              do_status;
  logic [1:0]        seen_inc;
  logic              done;
  logic [3:0]        hi;
  logic [3:0]        lo;

  assign hi = byte_i[7:4];
  assign lo = byte_i[3:0];

  always_comb begin
    st        = state_i;
    cnt       = 2'd0;
    res[0]    = '0;
    res[1]    = '0;
    do_data   = 1'b0;
    do_status = 1'b0;
    seen_inc  = state_i.data_seen + 2'd1;
    done      = (seen_inc >= state_i.data_needed);

    // Phase tracking: header, body byte or byte after a timestamp
    if (first_i) begin
      st.phase = blmd_pkg::PH_BODY;
    end else begin
      unique case (state_i.phase)
        blmd_pkg::PH_BODY: begin
          if (byte_i[7]) st.phase = blmd_pkg::PH_STAMP;
          else           do_data  = 1'b1;
        end
        blmd_pkg::PH_STAMP: begin
          st.phase = blmd_pkg::PH_BODY;
          if (byte_i[7]) do_status = 1'b1;
          else           do_data   = 1'b1;
        end
        default: st.phase = blmd_pkg::PH_HEADER;
      endcase
    end

    // Data byte: sysex payload or running-status data
    if (do_data) begin
      if (state_i.in_sysex) begin
        res[cnt[0]].midi_byte      = byte_i;
        res[cnt[0]].end_of_message = 1'b0;
        cnt                        = cnt + 2'd1;
      end else if (state_i.running_status != blmd_pkg::ST_NONE &&
                   state_i.data_needed != 2'd0) begin
        if (!state_i.status_sent) begin
          res[cnt[0]].midi_byte      = state_i.running_status;
          res[cnt[0]].end_of_message = 1'b0;
          cnt                        = cnt + 2'd1;
        end
        res[cnt[0]].midi_byte      = byte_i;
        res[cnt[0]].end_of_message = done;
        cnt                        = cnt + 2'd1;
        st.status_sent = 1'b1;
        st.data_seen   = seen_inc;
        if (done) begin
          st.data_seen   = 2'd0;
          st.status_sent = 1'b0;
          if (state_i.running_status >= blmd_pkg::ST_SYSTEM_MIN) begin
            st.running_status = blmd_pkg::ST_NONE;
            st.data_needed    = 2'd0;
          end
        end
      end
    end

    // Status byte
    if (do_status) begin
      if (byte_i >= blmd_pkg::ST_REALTIME) begin
        // real-time passes alone, state untouched
        res[cnt[0]].midi_byte      = byte_i;
        res[cnt[0]].end_of_message = 1'b1;
        cnt                        = cnt + 2'd1;
      end else begin
        // any other status closes an open sysex
        if (state_i.in_sysex) begin
          res[cnt[0]].midi_byte      = blmd_pkg::ST_SYSEX_END;
          res[cnt[0]].end_of_message = 1'b1;
          cnt                        = cnt + 2'd1;
          st.in_sysex                = 1'b0;
        end
        if (byte_i == blmd_pkg::ST_SYSEX_END) begin
          st.running_status = blmd_pkg::ST_NONE;
          st.data_needed    = 2'd0;
          st.data_seen      = 2'd0;
          st.status_sent    = 1'b0;
        end else if (byte_i == blmd_pkg::ST_SYSEX) begin
          st.running_status          = blmd_pkg::ST_NONE;
          st.data_needed             = 2'd0;
          st.data_seen               = 2'd0;
          st.status_sent             = 1'b0;
          st.in_sysex                = 1'b1;
          res[cnt[0]].midi_byte      = byte_i;
          res[cnt[0]].end_of_message = 1'b0;
          cnt                        = cnt + 2'd1;
        end else if (hi == blmd_pkg::HI_SYSTEM) begin
          st.running_status = blmd_pkg::ST_NONE;
          st.data_needed    = 2'd0;
          st.data_seen      = 2'd0;
          st.status_sent    = 1'b0;
          if (lo == blmd_pkg::LO_QFRAME || lo == blmd_pkg::LO_SONGSEL ||
              lo == blmd_pkg::LO_SONGPOS) begin
            st.data_needed    = (lo == blmd_pkg::LO_SONGPOS) ? 2'd2 : 2'd1;
            st.running_status = byte_i;
            st.status_sent    = 1'b1;
            res[cnt[0]].midi_byte      = byte_i;
            res[cnt[0]].end_of_message = 1'b0;
            cnt                        = cnt + 2'd1;
          end
        end else begin
          // channel message
          st.running_status = byte_i;
          st.data_needed    = (hi == blmd_pkg::HI_PROGRAM || hi == blmd_pkg::HI_PRESSURE)
                              ? 2'd1 : 2'd2;
          st.data_seen      = 2'd0;
          st.status_sent    = 1'b1;
          res[cnt[0]].midi_byte      = byte_i;
          res[cnt[0]].end_of_message = 1'b0;
          cnt                        = cnt + 2'd1;
        end
      end
    end

    // mark the final result of this byte
    if (cnt != 2'd0) res[~cnt[0]].last_for_input = 1'b1;
  end

  assign state_o     = st;
  assign dec_o.count = cnt;
  assign dec_o.res0  = res[0];
  assign dec_o.res1  = res[1];

endmodule

// ----- src/blmd_res_queue.sv -----
// ----------------------------------------------------------------------------
// blmd_res_queue: small result queue
// Takes up to two results per cycle and hands out one per cycle when popped;
// parts the parser from the output handshake until the queue fills.
// ----------------------------------------------------------------------------
module blmd_res_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blmd_pkg::dec_out_t push_i,
  input  logic               pop_i,
  output logic               space_o,
  output logic               valid_o,
  output blmd_pkg::result_t  head_o
);

  blmd_pkg::result_t                 mem_q [blmd_pkg::QDepth];
  logic [blmd_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [blmd_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [blmd_pkg::QCntW-1:0]        count_q, count_d;
  logic [blmd_pkg::QPtrW-1:0]        wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + {{(blmd_pkg::QPtrW-1){1'b0}}, 1'b1};

  // Pointer and fill arithmetic
  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.count;
    rd_ptr_d = rd_ptr_q + {{(blmd_pkg::QPtrW-1){1'b0}}, pop_i};
    count_d  = count_q + {1'b0, push_i.count}
               - {{(blmd_pkg::QCntW-1){1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q]  <= push_i.res0;
    if (push_i.count == 2'd2) mem_q[wr_ptr_nx] <= push_i.res1;
  end

  assign space_o = (count_q <= blmd_pkg::QCntW'(blmd_pkg::QDepth - 2));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

endmodule

// ----- tb/midi_stream_check.sv -----
// ----------------------------------------------------------------------------
// midi_stream_check: prediction and comparison for the BLE-MIDI deframer
// Watches both stream ports. Every accepted packet byte is run through a
// local model of the deframer, and the MIDI bytes it yields are queued.
// Every accepted output transaction is compared field by field with the
// oldest queued byte. Mismatch and pending counts go back to the top.
// ----------------------------------------------------------------------------
module midi_stream_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
  input  logic        s_axis_tuser,   // [0] first_of_packet
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] midi_byte
  input  logic        m_axis_tlast,   // end_of_message
  input  logic        m_axis_tuser,   // [0] last_for_input
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned compared_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Model state
  blmd_pkg::phase_e pkt_phase;
  logic [7:0]       run_status;
  logic [1:0]       data_need;
  logic [1:0]       data_got;
  logic             sysex_open;
  logic             status_out;

  // MIDI bytes still owed by the block
  blmd_pkg::result_t midi_q[$];
  int                step_cnt;
  int unsigned       fail_cnt;
  int unsigned       cmp_cnt;
  blmd_pkg::result_t got;
  blmd_pkg::result_t want;

  assign errors_o   = fail_cnt;
  assign compared_o = cmp_cnt;

  function automatic void emit(input logic [7:0] b, input logic eom);
    blmd_pkg::result_t r;
    r.midi_byte      = b;
    r.end_of_message = eom;
    r.last_for_input = 1'b0;
    midi_q.push_back(r);
    step_cnt++;
  endfunction

  function automatic void drop_running();
    run_status = blmd_pkg::ST_NONE;
    data_need  = 2'd0;
    data_got   = 2'd0;
    status_out = 1'b0;
  endfunction

  // Data byte: sysex payload, or data under the current (running) status
  function automatic void take_data(input logic [7:0] b);
    logic done;
    if (sysex_open) begin
      emit(b, 1'b0);
      return;
    end
    if (run_status == blmd_pkg::ST_NONE || data_need == 2'd0) return;
    if (!status_out) begin
      emit(run_status, 1'b0);
      status_out = 1'b1;
    end
    data_got = data_got + 2'd1;
    done = (data_got >= data_need);
    emit(b, done);
    if (done) begin
      data_got   = 2'd0;
      status_out = 1'b0;
      if (run_status >= blmd_pkg::ST_SYSTEM_MIN) drop_running();
    end
  endfunction

  // One packet byte through the model; queues what it yields
  function automatic void deframe(input logic [7:0] b, input logic first);
    blmd_pkg::result_t tail;
    step_cnt = 0;
    if (first) begin
      pkt_phase = blmd_pkg::PH_BODY;
      return;
    end
    case (pkt_phase)
      blmd_pkg::PH_BODY: begin
        if (b[7]) pkt_phase = blmd_pkg::PH_STAMP;
        else take_data(b);
      end
      blmd_pkg::PH_STAMP: begin
        pkt_phase = blmd_pkg::PH_BODY;
        if (!b[7]) begin
          take_data(b);
        end else if (b >= blmd_pkg::ST_REALTIME) begin
          emit(b, 1'b1);
        end else begin
          // any other status closes an open sysex first
          if (sysex_open && b != blmd_pkg::ST_SYSEX_END) begin
            emit(blmd_pkg::ST_SYSEX_END, 1'b1);
            sysex_open = 1'b0;
          end
          if (b == blmd_pkg::ST_SYSEX_END) begin
            drop_running();
            if (sysex_open) begin
              sysex_open = 1'b0;
              emit(b, 1'b1);
            end
          end else if (b == blmd_pkg::ST_SYSEX) begin
            drop_running();
            sysex_open = 1'b1;
            emit(b, 1'b0);
          end else if (b[7:4] == blmd_pkg::HI_SYSTEM) begin
            drop_running();
            if (b[3:0] == blmd_pkg::LO_QFRAME || b[3:0] == blmd_pkg::LO_SONGSEL)
              data_need = 2'd1;
            else if (b[3:0] == blmd_pkg::LO_SONGPOS)
              data_need = 2'd2;
            if (data_need != 2'd0) begin
              run_status = b;
              status_out = 1'b1;
              emit(b, 1'b0);
            end
          end else begin
            run_status = b;
            data_need  = (b[7:4] == blmd_pkg::HI_PROGRAM ||
                          b[7:4] == blmd_pkg::HI_PRESSURE) ? 2'd1 : 2'd2;
            data_got   = 2'd0;
            status_out = 1'b1;
            emit(b, 1'b0);
          end
        end
      end
      default: pkt_phase = blmd_pkg::PH_HEADER;
    endcase
    // mark the final byte of this input
    if (step_cnt > 0) begin
      tail = midi_q.pop_back();
      tail.last_for_input = 1'b1;
      midi_q.push_back(tail);
    end
  endfunction

  function automatic void flag(input string msg);
    if (fail_cnt < 10) $display("[%0t] MISMATCH %s", $realtime, msg);
    fail_cnt++;
  endfunction

  // Output is checked before the input of the same edge is modelled:
  // a result never leaves in the cycle its input is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_phase  = blmd_pkg::PH_HEADER;
      sysex_open = 1'b0;
      drop_running();
      midi_q.delete();
      fail_cnt   = 0;
      cmp_cnt    = 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.midi_byte      = m_axis_tdata;
        got.end_of_message = m_axis_tlast;
        got.last_for_input = m_axis_tuser;
        cmp_cnt++;
        if (midi_q.size() == 0) begin
          flag($sformatf("unexpected byte %02h eom=%0b last=%0b",
                         got.midi_byte, got.end_of_message, got.last_for_input));
        end else begin
          want = midi_q.pop_front();
          if (got.midi_byte !== want.midi_byte ||
              got.end_of_message !== want.end_of_message ||
              got.last_for_input !== want.last_for_input)
            flag($sformatf("exp %02h eom=%0b last=%0b, got %02h eom=%0b last=%0b",
                           want.midi_byte, want.end_of_message, want.last_for_input,
                           got.midi_byte, got.end_of_message, got.last_for_input));
        end
      end
      if (s_axis_tvalid && s_axis_tready) deframe(s_axis_tdata, s_axis_tuser);
      pending_o <= midi_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: top level for the BLE-MIDI packet deframer
// Drives directed packets covering headers, running status, system common,
// sysex across packets and real-time bytes, then random packets built from
// mostly well-formed messages plus noise, under four idle/stall mixes.
// The stream checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tuser  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  int unsigned errors;
  int unsigned pending;
  int unsigned compared;
  int unsigned bytes_sent = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          idle_mix[4]  = '{0, 53, 0, 29};
  int          stall_mix[4] = '{0, 0, 53, 29};
  int unsigned target;
  int unsigned failures;

  ble_midi_packet_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  midi_stream_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .errors_o      (errors),
    .pending_o     (pending),
    .compared_o    (compared)
  );

  // Clock and receiver back-pressure
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // One input transaction, with an optional random gap in front
  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_stamped(input logic [7:0] b);
    send_byte(8'($urandom_range(128, 255)), 1'b0);
    send_byte(b, 1'b0);
  endtask

  task automatic send_data(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 127)), 1'b0);
  endtask

  // Hold the input off until every queued MIDI byte has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One random message; mostly well formed, some broken, some noise
  task automatic send_message();
    int         kind;
    int         n;
    logic [7:0] st;
    kind = $urandom_range(99);
    if (kind < 40) begin
      // channel message, then a few running-status repeats
      st = 8'h80 + 8'($urandom_range(0, 111));
      n  = (st[7:4] == blmd_pkg::HI_PROGRAM ||
            st[7:4] == blmd_pkg::HI_PRESSURE) ? 1 : 2;
      send_stamped(st);
      send_data(n);
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(1)) send_byte(8'($urandom_range(128, 255)), 1'b0);
        send_data(n);
      end
    end else if (kind < 50) begin
      // system common, sometimes with a trailing bare data byte
      case ($urandom_range(2))
        0:       begin st = {blmd_pkg::HI_SYSTEM, blmd_pkg::LO_QFRAME};  n = 1; end
        1:       begin st = {blmd_pkg::HI_SYSTEM, blmd_pkg::LO_SONGPOS}; n = 2; end
        default: begin st = {blmd_pkg::HI_SYSTEM, blmd_pkg::LO_SONGSEL}; n = 1; end
      endcase
      send_stamped(st);
      send_data(n);
      if ($urandom_range(1)) send_data(1);
    end else if (kind < 60) begin
      send_stamped(blmd_pkg::ST_REALTIME + 8'($urandom_range(0, 7)));
    end else if (kind < 75) begin
      // sysex, possibly split over packets and possibly left open
      send_stamped(blmd_pkg::ST_SYSEX);
      send_data($urandom_range(0, 4));
      if ($urandom_range(3) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(1))
          send_stamped(blmd_pkg::ST_REALTIME + 8'($urandom_range(0, 7)));
        send_data($urandom_range(0, 3));
      end
      if ($urandom_range(1)) send_byte(8'($urandom_range(128, 255)), 1'b0);
      send_data($urandom_range(0, 1));
      if ($urandom_range(9) < 7) send_stamped(blmd_pkg::ST_SYSEX_END);
    end else if (kind < 85) begin
      // undefined system common, tune request or stray end of sysex
      send_stamped({blmd_pkg::HI_SYSTEM, 4'($urandom_range(4, 7))});
    end else if (kind < 90) begin
      // two-byte message cut short by whatever follows
      send_stamped(8'h80 + 8'($urandom_range(0, 47)));
      send_data(1);
    end else begin
      send_byte(8'($urandom_range(0, 255)), ($urandom_range(9) == 0));
    end
  endtask

  // Stimulus and verdict
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bytes before any header are dropped
    send_byte(8'h90, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b1);
    // data without status
    send_byte(8'h12, 1'b0);
    // note on, then running status re-emits the status
    send_byte(8'h80, 1'b0); send_byte(8'h90, 1'b0);
    send_byte(8'h3C, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h40, 1'b0);
    // program change, then a pitch bend abandoned by a new status
    send_byte(8'hFF, 1'b0); send_byte(8'hC5, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hE1, 1'b0); send_byte(8'h10, 1'b0);
    // channel pressure; data after timestamp under running status
    send_byte(8'h81, 1'b0); send_byte(8'hD3, 1'b0);
    send_byte(8'h81, 1'b0); send_byte(8'h20, 1'b0);
    // song position, bare data dropped, quarter frame, song select
    send_stamped({blmd_pkg::HI_SYSTEM, blmd_pkg::LO_SONGPOS}); send_data(3);
    send_stamped({blmd_pkg::HI_SYSTEM, blmd_pkg::LO_QFRAME});  send_data(1);
    send_stamped({blmd_pkg::HI_SYSTEM, blmd_pkg::LO_SONGSEL}); send_data(1);
    // undefined system common and stray end of sysex
    send_stamped(8'hF5); send_stamped(blmd_pkg::ST_SYSEX_END);
    // sysex over two packets, real-time inside, data after timestamp
    send_stamped(blmd_pkg::ST_SYSEX); send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1); send_byte(8'h02, 1'b0);
    send_byte(8'hC0, 1'b0); send_byte(8'h7F, 1'b0);
    send_stamped(8'hF8);
    // status inside sysex closes it first
    send_stamped(8'h90); send_data(2);
    send_stamped(blmd_pkg::ST_SYSEX); send_data(1);
    send_stamped(blmd_pkg::ST_SYSEX_END);

    // random packets under each idle/stall mix
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      target    = bytes_sent + 110;
      while (bytes_sent < target) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat ($urandom_range(1, 4)) send_message();
      end
      if (ph == 1) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);

    failures = errors + pending;
    if (pending != 0) $display("%0d MIDI bytes never arrived", pending);
    $display("Covered %0d packet bytes over four idle/stall mixes, %0d MIDI bytes compared",
             bytes_sent, compared);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200us;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
